// File: rtl/gpke_pkg.sv
package gpke_pkg;

   // Widths of the poll and of the button and direction words
   localparam int BUTTON_BITS    = 32;
   localparam int DIRECTION_BITS = 16;
   localparam int AXIS_W         = 16;
   localparam int SCALE_W        = 17;
   localparam int CSR_INDEX_W    = 3;
   localparam int CSR_DATA_W     = 17;

   // Axis handling limits
   localparam logic [2:0] DIR_AXES     = 3'd4;
   localparam logic [2:0] BALL_AXES    = 3'd6;
   localparam int         LEVEL_GAIN   = 127;
   localparam int         LEVEL_SHIFT  = 15;
   localparam int         MOVE_SHIFT   = 16;

   // Hat angles in hundredths of a degree
   localparam logic [15:0] HAT_FORWARD  = 16'd0;
   localparam logic [15:0] HAT_RIGHT    = 16'd9000;
   localparam logic [15:0] HAT_BACKWARD = 16'd18000;
   localparam logic [15:0] HAT_LEFT     = 16'd27000;

   // Register indexes on the csr port
   localparam logic [CSR_INDEX_W-1:0] CSR_BUTTON_COUNT = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_AXIS_COUNT   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HAT_PRESENT  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_X_AS_BUTTONS = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_Y_AS_BUTTONS = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEAD_ZONE    = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_BALL_SCALE   = 3'd6;

   typedef enum logic [1:0] {
      EV_BUTTON    = 2'd0,
      EV_DIRECTION = 2'd1,
      EV_ANALOG    = 2'd2,
      EV_MOVE      = 2'd3
   } event_kind_type;

   typedef enum logic {
      MUL_LEVEL = 1'b0,
      MUL_MOVE  = 1'b1
   } mul_op_type;

   typedef struct packed {
      logic [31:0] buttons;
      logic [15:0] axis_x;
      logic [15:0] axis_y;
      logic [15:0] axis_z;
      logic [15:0] axis_r;
      logic [15:0] axis_u;
      logic [15:0] axis_v;
      logic [15:0] hat_angle;
   } req_type;

   typedef struct packed {
      event_kind_type     event_kind;
      logic [4:0]         key_index;
      logic               pressed;
      logic               axis_select;
      logic signed [7:0]  axis_level;
      logic signed [15:0] move_dx;
      logic signed [15:0] move_dy;
      logic               last;
   } rsp_type;

   // Sequencer to event queue
   typedef struct packed {
      logic push;
      logic flush;
   } evq_cmd_type;

   // Event queue to sequencer
   typedef struct packed {
      logic ready;
      logic pend_valid;
   } evq_stat_type;

   // Raw axis minus center, as a signed count
   function automatic logic signed [AXIS_W-1:0] centered(input logic [AXIS_W-1:0] raw);
      return {~raw[AXIS_W-1], raw[AXIS_W-2:0]};
   endfunction

endpackage

// File: rtl/gpke_mul.sv
module gpke_mul
   import gpke_pkg::*;
(
   input  logic                     clock,
   input  logic                     load,
   input  mul_op_type               op,
   input  logic signed [AXIS_W-1:0] axis,
   input  logic [SCALE_W-1:0]       scale,
   output logic signed [7:0]        level,
   output logic signed [15:0]       move
);

   localparam int PROD_W = AXIS_W + SCALE_W + 1;

   logic signed [SCALE_W:0]   gain;
   logic signed [PROD_W-1:0]  prod_in;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [PROD_W-1:0]  lv_sum;
   logic signed [PROD_W-1:0]  lv_q;
   logic signed [PROD_W-1:0]  lv_neg;
   logic signed [PROD_W-1:0]  mv_sum;
   logic signed [PROD_W-1:0]  mv_q;

   // Pick the gain and multiply
   always_comb begin
      gain    = (op == MUL_LEVEL) ? (SCALE_W+1)'(LEVEL_GAIN) : $signed({1'b0, scale});
      prod_in = PROD_W'(axis) * PROD_W'(gain);
   end

   // Hold the product until the next load
   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= prod_in;
      end
   end

   // Divide by a power of two, truncating toward zero, and negate the level
   always_comb begin
      lv_sum = prod_ff + (prod_ff[PROD_W-1] ? PROD_W'((1 << LEVEL_SHIFT) - 1) : '0);
      lv_q   = lv_sum >>> LEVEL_SHIFT;
      lv_neg = -lv_q;
      level  = lv_neg[7:0];

      mv_sum = prod_ff + (prod_ff[PROD_W-1] ? PROD_W'((1 << MOVE_SHIFT) - 1) : '0);
      mv_q   = mv_sum >>> MOVE_SHIFT;
      // Saturate to sixteen bits
      if (mv_q > PROD_W'(32767)) begin
         move = 16'sh7FFF;
      end else if (mv_q < -PROD_W'(32768)) begin
         move = 16'sh8000;
      end else begin
         move = mv_q[15:0];
      end
   end

endmodule

// File: rtl/gpke_evq.sv
module gpke_evq
   import gpke_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  evq_cmd_type  cmd,
   input  rsp_type      ev,
   output evq_stat_type stat,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_type      rsp_data
);

   logic    pend_valid_ff, pend_valid_in;
   rsp_type pend_ff, pend_in;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type out_ff, out_in;
   logic    out_free;
   logic    ready;
   logic    load_out;

   // One event waits in pend so the final one can be marked last
   always_comb begin
      out_free      = !rsp_valid_ff || !rsp_stall;
      ready         = !pend_valid_ff || out_free;
      load_out      = ready && pend_valid_ff && (cmd.push || cmd.flush);
      rsp_valid_in  = load_out || (rsp_valid_ff && rsp_stall);
      out_in        = out_ff;
      if (load_out) begin
         out_in      = pend_ff;
         out_in.last = cmd.flush;
      end
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      if (ready && cmd.push) begin
         pend_valid_in = 1'b1;
         pend_in       = ev;
      end else if (ready && cmd.flush) begin
         pend_valid_in = 1'b0;
      end
      stat.ready      = ready;
      stat.pend_valid = pend_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      pend_ff <= pend_in;
      out_ff  <= out_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = out_ff;

endmodule

// File: rtl/gamepad_poll_to_key_events_unit.sv
// Gamepad poll to key events.
// req channel: one poll per item (buttons, six raw axes, hat angle), valid/stall.
// rsp channel: one event per item, valid/stall; the last event of a poll has last set.
// A poll with no changes gives no event, but each analog axis gives an event on every poll.
// csr port: write csr_wdata to register csr_index while csr_we is high; the user must
// write only while idle, which the block itself does not enforce. A poll passes through
// the scan of the nb enabled buttons, the axes among the first four (each analog axis
// with a wait for the multiplier), the sixteen direction bits, the trackball steps when
// the axis count is six or more, and the flush. The scan visits one button or direction
// bit per cycle while the hold stage can take its event, and the analog level and
// trackball moves share one multiplier. req_stall stays high from acceptance until the
// last event has gone into the output register. Each event waits in a one-entry hold
// stage until the next event is found or the scan ends, then moves to the output
// register; while rsp_stall is high the scan waits on the next event found. Reset clears
// the previous button and direction words and loads the register defaults.
module gamepad_poll_to_key_events_unit
   import gpke_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int BIDX_W = $clog2(BUTTON_BITS);
   localparam int DIDX_W = $clog2(DIRECTION_BITS);

   typedef enum logic [3:0] {
      S_IDLE, S_BTN, S_AXIS, S_AXWAIT, S_DIR, S_BALL_U, S_BALL_V, S_BALL_W, S_FLUSH
   } state_type;

   // Configuration registers
   logic [5:0]          button_count_ff;
   logic [2:0]          axis_count_ff;
   logic                hat_present_ff;
   logic                x_as_buttons_ff;
   logic                y_as_buttons_ff;
   logic [15:0]         dead_zone_ff;
   logic [SCALE_W-1:0]  ball_scale_ff;

   // Sequencer registers
   state_type                 state_ff, state_in;
   req_type                   req_ff, req_in;
   logic [BUTTON_BITS-1:0]    bdiff_ff, bdiff_in;
   logic [BUTTON_BITS-1:0]    bnow_ff, bnow_in;
   logic [31:0]               prev_buttons_ff, prev_buttons_in;
   logic [DIRECTION_BITS-1:0] ddiff_ff, ddiff_in;
   logic [DIRECTION_BITS-1:0] dnow_ff, dnow_in;
   logic [DIRECTION_BITS-1:0] prev_dirs_ff, prev_dirs_in;
   logic [7:0]                dirs_ff, dirs_in;
   logic [BIDX_W-1:0]         bidx_ff, bidx_in;
   logic [DIDX_W-1:0]         didx_ff, didx_in;
   logic [2:0]                ax_ff, ax_in;
   logic                      outside_ff, outside_in;
   logic signed [15:0]        dx_ff, dx_in;

   // Combinational helpers
   logic [5:0]                nb;
   logic [2:0]                axis_lim;
   logic                      ball_en;
   logic [15:0]               ax_raw;
   logic signed [AXIS_W-1:0]  c_cur;
   logic signed [AXIS_W+1:0]  c_ext;
   logic signed [AXIS_W+1:0]  dz_ext;
   logic                      below;
   logic                      above;
   logic                      analog;
   logic [3:0]                hat_bits;
   logic [DIRECTION_BITS-1:0] dfull;

   logic                      mul_load;
   mul_op_type                mul_op;
   logic signed [AXIS_W-1:0]  mul_axis;
   logic signed [7:0]         mul_level;
   logic signed [15:0]        mul_move;

   evq_cmd_type               cmd;
   evq_stat_type              evq_stat;
   rsp_type                   ev;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         button_count_ff <= 6'd32;
         axis_count_ff   <= 3'd6;
         hat_present_ff  <= 1'b1;
         x_as_buttons_ff <= 1'b1;
         y_as_buttons_ff <= 1'b0;
         dead_zone_ff    <= 16'd4915;
         ball_scale_ff   <= 17'd1311;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BUTTON_COUNT: button_count_ff <= csr_wdata[5:0];
            CSR_AXIS_COUNT:   axis_count_ff   <= csr_wdata[2:0];
            CSR_HAT_PRESENT:  hat_present_ff  <= csr_wdata[0];
            CSR_X_AS_BUTTONS: x_as_buttons_ff <= csr_wdata[0];
            CSR_Y_AS_BUTTONS: y_as_buttons_ff <= csr_wdata[0];
            CSR_DEAD_ZONE:    dead_zone_ff    <= csr_wdata[15:0];
            CSR_BALL_SCALE:   ball_scale_ff   <= csr_wdata[SCALE_W-1:0];
            default: ;
         endcase
      end
   end

   // Clamp counts, pick the current axis, compare it to the dead zone and build the direction word
   always_comb begin
      nb       = (button_count_ff > 6'(BUTTON_BITS)) ? 6'(BUTTON_BITS) : button_count_ff;
      axis_lim = (axis_count_ff > DIR_AXES) ? DIR_AXES : axis_count_ff;
      ball_en  = (axis_count_ff >= BALL_AXES);
      case (ax_ff[1:0])
         2'd0:    ax_raw = req_ff.axis_x;
         2'd1:    ax_raw = req_ff.axis_y;
         2'd2:    ax_raw = req_ff.axis_z;
         default: ax_raw = req_ff.axis_r;
      endcase
      c_cur    = centered(ax_raw);
      c_ext    = (AXIS_W+2)'(c_cur);
      dz_ext   = $signed({2'b00, dead_zone_ff});
      below    = c_ext < -dz_ext;
      above    = c_ext > dz_ext;
      analog   = ((ax_ff == 3'd0) && !x_as_buttons_ff) || ((ax_ff == 3'd1) && !y_as_buttons_ff);
      hat_bits[0] = hat_present_ff && (req_ff.hat_angle == HAT_FORWARD);
      hat_bits[1] = hat_present_ff && (req_ff.hat_angle == HAT_BACKWARD);
      hat_bits[2] = hat_present_ff && (req_ff.hat_angle == HAT_RIGHT);
      hat_bits[3] = hat_present_ff && (req_ff.hat_angle == HAT_LEFT);
      dfull    = {hat_bits, 4'b0000, dirs_ff};
   end

   // Sequence the scan of one poll
   always_comb begin
      state_in        = state_ff;
      req_in          = req_ff;
      bdiff_in        = bdiff_ff;
      bnow_in         = bnow_ff;
      prev_buttons_in = prev_buttons_ff;
      ddiff_in        = ddiff_ff;
      dnow_in         = dnow_ff;
      prev_dirs_in    = prev_dirs_ff;
      dirs_in         = dirs_ff;
      bidx_in         = bidx_ff;
      didx_in         = didx_ff;
      ax_in           = ax_ff;
      outside_in      = outside_ff;
      dx_in           = dx_ff;
      ev              = '0;
      cmd             = '0;
      mul_load        = 1'b0;
      mul_op          = MUL_LEVEL;
      mul_axis        = c_cur;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in          = req_data;
               bdiff_in        = req_data.buttons ^ prev_buttons_ff;
               bnow_in         = req_data.buttons;
               prev_buttons_in = req_data.buttons;
               bidx_in         = '0;
               ax_in           = '0;
               dirs_in         = '0;
               state_in        = (nb == 6'd0) ? S_AXIS : S_BTN;
            end
         end
         S_BTN: begin
            ev.event_kind = EV_BUTTON;
            ev.key_index  = 5'(bidx_ff);
            ev.pressed    = bnow_ff[bidx_ff];
            cmd.push      = bdiff_ff[bidx_ff];
            if (!cmd.push || evq_stat.ready) begin
               bidx_in = bidx_ff + BIDX_W'(1);
               if ({1'b0, bidx_ff} == nb - 6'd1) begin
                  state_in = S_AXIS;
               end
            end
         end
         S_AXIS: begin
            if (ax_ff < axis_lim) begin
               if (analog) begin
                  mul_load   = 1'b1;
                  outside_in = below || above;
                  state_in   = S_AXWAIT;
               end else begin
                  if (below) begin
                     dirs_in[{ax_ff[1:0], 1'b0}] = 1'b1;
                  end else if (above) begin
                     dirs_in[{ax_ff[1:0], 1'b1}] = 1'b1;
                  end
                  ax_in = ax_ff + 3'd1;
               end
            end else begin
               ddiff_in     = dfull ^ prev_dirs_ff;
               dnow_in      = dfull;
               prev_dirs_in = dfull;
               didx_in      = '0;
               state_in     = S_DIR;
            end
         end
         S_AXWAIT: begin
            ev.event_kind  = EV_ANALOG;
            ev.axis_select = ax_ff[0];
            ev.axis_level  = outside_ff ? mul_level : 8'sd0;
            cmd.push       = 1'b1;
            if (evq_stat.ready) begin
               ax_in    = ax_ff + 3'd1;
               state_in = S_AXIS;
            end
         end
         S_DIR: begin
            ev.event_kind = EV_DIRECTION;
            ev.key_index  = 5'(didx_ff);
            ev.pressed    = dnow_ff[didx_ff];
            cmd.push      = ddiff_ff[didx_ff];
            if (!cmd.push || evq_stat.ready) begin
               didx_in = didx_ff + DIDX_W'(1);
               if (didx_ff == DIDX_W'(DIRECTION_BITS - 1)) begin
                  state_in = ball_en ? S_BALL_U : S_FLUSH;
               end
            end
         end
         S_BALL_U: begin
            mul_load = 1'b1;
            mul_op   = MUL_MOVE;
            mul_axis = centered(req_ff.axis_u);
            state_in = S_BALL_V;
         end
         S_BALL_V: begin
            mul_load = 1'b1;
            mul_op   = MUL_MOVE;
            mul_axis = centered(req_ff.axis_v);
            dx_in    = mul_move;
            state_in = S_BALL_W;
         end
         S_BALL_W: begin
            ev.event_kind = EV_MOVE;
            ev.move_dx    = dx_ff;
            ev.move_dy    = mul_move;
            cmd.push      = (dx_ff != 16'sd0) || (mul_move != 16'sd0);
            if (!cmd.push || evq_stat.ready) begin
               state_in = S_FLUSH;
            end
         end
         S_FLUSH: begin
            cmd.flush = 1'b1;
            if (evq_stat.ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Hold sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         prev_buttons_ff <= '0;
         prev_dirs_ff    <= '0;
      end else begin
         state_ff        <= state_in;
         prev_buttons_ff <= prev_buttons_in;
         prev_dirs_ff    <= prev_dirs_in;
      end
      req_ff     <= req_in;
      bdiff_ff   <= bdiff_in;
      bnow_ff    <= bnow_in;
      ddiff_ff   <= ddiff_in;
      dnow_ff    <= dnow_in;
      dirs_ff    <= dirs_in;
      bidx_ff    <= bidx_in;
      didx_ff    <= didx_in;
      ax_ff      <= ax_in;
      outside_ff <= outside_in;
      dx_ff      <= dx_in;
   end

   assign req_stall = (state_ff != S_IDLE);

   gpke_mul u_mul (
      .clock (clock),
      .load  (mul_load),
      .op    (mul_op),
      .axis  (mul_axis),
      .scale (ball_scale_ff),
      .level (mul_level),
      .move  (mul_move)
   );

   gpke_evq u_evq (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .ev        (ev),
      .stat      (evq_stat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // Every event of a poll has left the hold stage before the next poll
   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !evq_stat.pend_valid)
      else $error("event still pending while idle");

   // The button scan stays within the enabled buttons
   a_btn_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_BTN) |-> ({1'b0, bidx_ff} < nb))
      else $error("button index beyond button count");

   // An accepted poll blocks the next one
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("poll accepted back to back");

endmodule
